/* sv/deque_with_positional_insert_top_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the deque block
// Shared concurrent assertion forms, sampled on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef DEQUE_WITH_POSITIONAL_INSERT_TOP_ASSERT_SVH
`define DEQUE_WITH_POSITIONAL_INSERT_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DQ_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define DQ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/dq_pkg.sv */
// ----------------------------------------------------------------------------
// dq_pkg
// Opcodes, status codes and the controller/datapath link types of the deque.
// ----------------------------------------------------------------------------
package dq_pkg;

    typedef enum logic [2:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_REAR  = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_REAR   = 3'd3,
        OP_INSERT     = 3'd4,
        OP_READ_ALL   = 3'd5
    } opcode_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2,
        ST_NOPOS = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        CMD_IDLE,
        CMD_PUSH_FRONT,
        CMD_PUSH_REAR,
        CMD_POP_FRONT,
        CMD_POP_REAR,
        CMD_INSERT,
        CMD_ROTATE
    } cmd_t;

    // Command from the controller to the datapath.
    typedef struct packed {
        cmd_t    cmd;
        logic    load;
        status_t status;
        logic    value_valid;
        logic    last;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic empty;
        logic full;
        logic pos_bad;
        logic rd_last;
    } dp_stat_t;

endpackage

/* sv/dq_req_if.sv */
// ----------------------------------------------------------------------------
// dq_req_if
// Request channel of the deque: one operation word per handshake.
// ----------------------------------------------------------------------------
interface dq_req_if;
    logic               valid;
    logic               ready;
    logic [2:0]         opcode;
    logic signed [31:0] value_in;
    logic [7:0]         position;

    modport source (output valid, output opcode, output value_in, output position,
                    input ready);
    modport sink   (input valid, input opcode, input value_in, input position,
                    output ready);
endinterface

/* sv/dq_rsp_if.sv */
// ----------------------------------------------------------------------------
// dq_rsp_if
// Response channel of the deque: one result word per handshake.
// ----------------------------------------------------------------------------
interface dq_rsp_if;
    logic               valid;
    logic               ready;
    logic [1:0]         status;
    logic signed [31:0] value_out;
    logic               value_valid;
    logic               last;

    modport source (output valid, output status, output value_out,
                    output value_valid, output last, input ready);
    modport sink   (input valid, input status, input value_out,
                    input value_valid, input last, output ready);
endinterface

/* sv/dq_ctrl.sv */
// ----------------------------------------------------------------------------
// dq_ctrl
// Controller: decodes operations, sequences read-out and owns the output
// valid flag.
// ----------------------------------------------------------------------------
`include "deque_with_positional_insert_top_assert.svh"

module dq_ctrl
    import dq_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    output logic     req_ready,
    input  logic [2:0] opcode,
    output logic     rsp_valid,
    input  logic     rsp_ready,
    input  dp_stat_t stat,
    output dp_cmd_t  dp_cmd
);

    typedef enum logic {
        S_IDLE,
        S_READ
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    assign out_free  = !out_valid_reg || rsp_ready;
    assign req_ready = (state_reg == S_IDLE) && out_free;
    assign rsp_valid = out_valid_reg;

    always_comb
    begin
        state_next         = state_reg;
        dp_cmd.cmd         = CMD_IDLE;
        dp_cmd.load        = 1'b0;
        dp_cmd.status      = ST_OK;
        dp_cmd.value_valid = 1'b0;
        dp_cmd.last        = 1'b1;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid && req_ready)
                begin
                    case (opcode)
                        OP_PUSH_FRONT, OP_PUSH_REAR:
                        begin
                            dp_cmd.load = 1'b1;
                            if (stat.full)
                            begin
                                dp_cmd.status = ST_FULL;
                            end
                            else
                            begin
                                dp_cmd.cmd = (opcode == OP_PUSH_FRONT) ? CMD_PUSH_FRONT
                                                                       : CMD_PUSH_REAR;
                            end
                        end
                        OP_POP_FRONT, OP_POP_REAR:
                        begin
                            dp_cmd.load = 1'b1;
                            if (stat.empty)
                            begin
                                dp_cmd.status = ST_EMPTY;
                            end
                            else
                            begin
                                dp_cmd.cmd = (opcode == OP_POP_FRONT) ? CMD_POP_FRONT
                                                                      : CMD_POP_REAR;
                                dp_cmd.value_valid = 1'b1;
                            end
                        end
                        OP_INSERT:
                        begin
                            dp_cmd.load = 1'b1;
                            if (stat.full)
                            begin
                                dp_cmd.status = ST_FULL;
                            end
                            else if (stat.pos_bad)
                            begin
                                dp_cmd.status = ST_NOPOS;
                            end
                            else
                            begin
                                dp_cmd.cmd = CMD_INSERT;
                            end
                        end
                        OP_READ_ALL:
                        begin
                            if (stat.empty)
                            begin
                                dp_cmd.load   = 1'b1;
                                dp_cmd.status = ST_EMPTY;
                            end
                            else
                            begin
                                state_next = S_READ;
                            end
                        end
                        default:
                        begin
                            // Unused opcodes are taken and dropped without a result.
                        end
                    endcase
                end
            end
            S_READ:
            begin
                if (out_free)
                begin
                    dp_cmd.cmd         = CMD_ROTATE;
                    dp_cmd.load        = 1'b1;
                    dp_cmd.value_valid = 1'b1;
                    dp_cmd.last        = stat.rd_last;
                    if (stat.rd_last)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign out_valid_next = dp_cmd.load ? 1'b1 : (rsp_ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    `DQ_ASSERT_SAME(a_no_accept_in_read, state_reg == S_READ, !req_ready, "request taken during read-out")
    `DQ_ASSERT_SAME(a_load_needs_slot, dp_cmd.load, out_free, "result loaded over a pending word")
    `DQ_ASSERT_NEXT(a_read_ends, (dp_cmd.cmd == CMD_ROTATE) && stat.rd_last, state_reg == S_IDLE, "read-out did not finish")

endmodule

/* sv/dq_datapath.sv */
// ----------------------------------------------------------------------------
// dq_datapath
// Shift-register entry cells, entry count, read-out counter and the output
// payload register.
// ----------------------------------------------------------------------------
`include "deque_with_positional_insert_top_assert.svh"

module dq_datapath
    import dq_pkg::*;
#(
    parameter int CAPACITY = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic signed [31:0] value_in,
    input  logic [7:0]         position,
    input  dp_cmd_t            dp_cmd,
    output dp_stat_t           stat,
    output logic [1:0]         status,
    output logic signed [31:0] value_out,
    output logic               value_valid,
    output logic               last
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = $clog2(CAPACITY);

    logic signed [31:0] cell_reg  [CAPACITY];
    logic signed [31:0] cell_next [CAPACITY];
    logic [CW-1:0]      count_reg, count_next;
    logic [CW-1:0]      rd_cnt_reg, rd_cnt_next;
    logic [CW-1:0]      count_m1;
    logic [IW-1:0]      place_idx;
    logic               do_place;
    logic signed [31:0] rear_value;
    logic signed [31:0] sel_value;

    status_t            status_reg;
    logic signed [31:0] value_reg;
    logic               value_valid_reg;
    logic               last_reg;

    assign count_m1 = count_reg - CW'(1);

    assign stat.empty   = (count_reg == '0);
    assign stat.full    = (count_reg == CW'(CAPACITY));
    assign stat.pos_bad = (count_reg == '0) || (position > 8'(count_reg));
    assign stat.rd_last = (rd_cnt_reg == count_m1);

    assign do_place = (dp_cmd.cmd == CMD_PUSH_FRONT) || (dp_cmd.cmd == CMD_PUSH_REAR)
                      || (dp_cmd.cmd == CMD_INSERT);

    always_comb
    begin
        case (dp_cmd.cmd)
            CMD_PUSH_REAR: place_idx = count_reg[IW-1:0];
            CMD_INSERT:    place_idx = (position <= 8'd1) ? '0 : IW'(position - 8'd1);
            default:       place_idx = '0;
        endcase
    end

    // The rear entry sits at count-1; only read when the queue is not empty.
    assign rear_value = cell_reg[count_m1[IW-1:0]];

    for (genvar g = 0; g < CAPACITY; g++)
    begin : g_cell
        logic signed [31:0] up_value;
        logic signed [31:0] down_value;

        if (g < CAPACITY - 1)
        begin : g_up
            assign up_value = cell_reg[g + 1];
        end
        else
        begin : g_up_end
            assign up_value = cell_reg[g];
        end

        if (g > 0)
        begin : g_down
            assign down_value = cell_reg[g - 1];
        end
        else
        begin : g_down_end
            assign down_value = cell_reg[g];
        end

        always_comb
        begin
            cell_next[g] = cell_reg[g];
            if (do_place)
            begin
                if (IW'(g) == place_idx)
                begin
                    cell_next[g] = value_in;
                end
                else if (IW'(g) > place_idx)
                begin
                    cell_next[g] = down_value;
                end
            end
            else if (dp_cmd.cmd == CMD_POP_FRONT)
            begin
                cell_next[g] = up_value;
            end
            else if (dp_cmd.cmd == CMD_ROTATE)
            begin
                // The occupied cells turn round by one, so the front is always at cell 0.
                if (CW'(g) < count_m1)
                begin
                    cell_next[g] = up_value;
                end
                else if (CW'(g) == count_m1)
                begin
                    cell_next[g] = cell_reg[0];
                end
            end
        end

        always_ff @(posedge clk)
        begin
            cell_reg[g] <= cell_next[g];
        end
    end

    always_comb
    begin
        count_next = count_reg;
        case (dp_cmd.cmd)
            CMD_PUSH_FRONT, CMD_PUSH_REAR, CMD_INSERT: count_next = count_reg + CW'(1);
            CMD_POP_FRONT, CMD_POP_REAR:               count_next = count_m1;
            default:                                   count_next = count_reg;
        endcase
    end

    // The read-out position holds while the output is stalled and returns to
    // zero after the last entry.
    always_comb
    begin
        if (dp_cmd.cmd == CMD_ROTATE)
        begin
            rd_cnt_next = stat.rd_last ? '0 : rd_cnt_reg + CW'(1);
        end
        else
        begin
            rd_cnt_next = rd_cnt_reg;
        end
    end

    always_comb
    begin
        case (dp_cmd.cmd)
            CMD_POP_FRONT, CMD_ROTATE: sel_value = cell_reg[0];
            CMD_POP_REAR:              sel_value = rear_value;
            default:                   sel_value = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            rd_cnt_reg <= '0;
        end
        else
        begin
            count_reg  <= count_next;
            rd_cnt_reg <= rd_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (dp_cmd.load)
        begin
            status_reg      <= dp_cmd.status;
            value_reg       <= sel_value;
            value_valid_reg <= dp_cmd.value_valid;
            last_reg        <= dp_cmd.last;
        end
    end

    assign status      = status_reg;
    assign value_out   = value_reg;
    assign value_valid = value_valid_reg;
    assign last        = last_reg;

    `DQ_ASSERT_SAME(a_count_bound, 1'b1, count_reg <= CW'(CAPACITY), "entry count above capacity")
    `DQ_ASSERT_SAME(a_no_place_full, do_place, !stat.full, "entry placed into a full store")
    `DQ_ASSERT_NEXT(a_pop_count, (dp_cmd.cmd == CMD_POP_FRONT) || (dp_cmd.cmd == CMD_POP_REAR), count_reg == $past(count_reg) - CW'(1), "pop did not lower the count")

endmodule

/* sv/deque_with_positional_insert_top.sv */
// A push, pop or insert result word is offered in the cycle after its request word is taken.
// One push, pop or insert request is taken per cycle while the output register is free.
// Read-out of N entries: the accept step, then one rotate of the cells per entry.
// Reset clears the entry count and the output valid flag; the entry cells are not cleared.
// ----------------------------------------------------------------------------
// deque_with_positional_insert_top
// Bounded double-ended queue with positional insert and full read-out.
// ----------------------------------------------------------------------------
module deque_with_positional_insert_top
    import dq_pkg::*;
#(
    parameter int CAPACITY = 16
)
(
    input  logic clk,
    input  logic rst_n,
    dq_req_if.sink   req,
    dq_rsp_if.source rsp
);

    dp_cmd_t  dp_cmd;
    dp_stat_t stat;

    dq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .opcode    (req.opcode),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .stat      (stat),
        .dp_cmd    (dp_cmd)
    );

    dq_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .value_in    (req.value_in),
        .position    (req.position),
        .dp_cmd      (dp_cmd),
        .stat        (stat),
        .status      (rsp.status),
        .value_out   (rsp.value_out),
        .value_valid (rsp.value_valid),
        .last        (rsp.last)
    );

endmodule

/* verif/deque_with_positional_insert_checker.sv */
// ----------------------------------------------------------------------------
// Deque result checker
// Watches the request and response channels, keeps its own copy of the deque
// contents, predicts every result word and compares it as it arrives.
// ----------------------------------------------------------------------------
module deque_with_positional_insert_checker
    import dq_pkg::*;
#(
    parameter int CAPACITY = 16
)
(
    input  logic clk,
    input  logic rst_n,
    dq_req_if    req,
    dq_rsp_if    rsp,
    output int   fail_count,
    output int   pending,
    output int   words_checked,
    output int   full_seen,
    output int   empty_seen,
    output int   nopos_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        status_t     status;
        logic [31:0] value;
        logic        value_valid;
        logic        last;
    } deque_word_t;

    logic [31:0] deque_cells [CAPACITY];
    int          deque_len;
    deque_word_t owed_results [$];

    // Shifts the entries from idx onwards one place towards the rear.
    task automatic open_slot(input int idx, input logic [31:0] v);
        int i;
        for (i = deque_len; i > idx; i--)
            deque_cells[i] = deque_cells[i - 1];
        deque_cells[idx] = v;
        deque_len++;
    endtask

    task automatic step_deque(input logic [2:0] op, input logic [31:0] v,
                              input logic [7:0] pos);
        deque_word_t w;
        int          i;
        w.status      = ST_OK;
        w.value       = '0;
        w.value_valid = 1'b0;
        w.last        = 1'b1;
        case (op)
            OP_PUSH_FRONT, OP_PUSH_REAR:
            begin
                if (deque_len >= CAPACITY)
                    w.status = ST_FULL;
                else
                    open_slot((op == OP_PUSH_FRONT) ? 0 : deque_len, v);
                owed_results.push_back(w);
            end
            OP_POP_FRONT, OP_POP_REAR:
            begin
                if (deque_len == 0)
                    w.status = ST_EMPTY;
                else
                begin
                    w.value_valid = 1'b1;
                    if (op == OP_POP_FRONT)
                    begin
                        w.value = deque_cells[0];
                        for (i = 1; i < deque_len; i++)
                            deque_cells[i - 1] = deque_cells[i];
                    end
                    else
                        w.value = deque_cells[deque_len - 1];
                    deque_len--;
                end
                owed_results.push_back(w);
            end
            OP_INSERT:
            begin
                // The full check takes priority over the position check.
                if (deque_len >= CAPACITY)
                    w.status = ST_FULL;
                else if (deque_len == 0 || int'(pos) > deque_len)
                    w.status = ST_NOPOS;
                else
                    open_slot((pos <= 8'd1) ? 0 : int'(pos) - 1, v);
                owed_results.push_back(w);
            end
            OP_READ_ALL:
            begin
                if (deque_len == 0)
                begin
                    w.status = ST_EMPTY;
                    owed_results.push_back(w);
                end
                else
                begin
                    for (i = 0; i < deque_len; i++)
                    begin
                        w.value       = deque_cells[i];
                        w.value_valid = 1'b1;
                        w.last        = (i == deque_len - 1);
                        owed_results.push_back(w);
                    end
                end
            end
            default:
            begin
                // Unused opcodes leave the deque alone and produce no word.
            end
        endcase
    endtask

    task automatic check_word();
        deque_word_t want;
        words_checked++;
        if (owed_results.size() == 0)
        begin
            fail_count++;
            if (fail_count <= 10)
                $display("unexpected result word: status %0d value %h valid %b last %b",
                         rsp.status, rsp.value_out, rsp.value_valid, rsp.last);
        end
        else
        begin
            want = owed_results.pop_front();
            case (want.status)
                ST_FULL:  full_seen++;
                ST_EMPTY: empty_seen++;
                ST_NOPOS: nopos_seen++;
                default:  ;
            endcase
            if (rsp.status !== want.status || rsp.value_out !== want.value
                || rsp.value_valid !== want.value_valid || rsp.last !== want.last)
            begin
                fail_count++;
                if (fail_count <= 10)
                    $display("result mismatch: expected status %0d value %h valid %b last %b, got status %0d value %h valid %b last %b",
                             want.status, want.value, want.value_valid, want.last,
                             rsp.status, rsp.value_out, rsp.value_valid, rsp.last);
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            deque_len     = 0;
            owed_results.delete();
            fail_count    = 0;
            words_checked = 0;
            full_seen     = 0;
            empty_seen    = 0;
            nopos_seen    = 0;
            pending      <= 0;
        end
        else
        begin
            if (req.valid && req.ready)
                step_deque(req.opcode, req.value_in, req.position);
            if (rsp.valid && rsp.ready)
                check_word();
            pending <= owed_results.size();
        end
    end

endmodule

/* verif/deque_with_positional_insert_top_tb.sv */
// ----------------------------------------------------------------------------
// Deque testbench
// Directed corner cases, then fill, drain and mixed random bursts under three
// mixes of sender and receiver idling; the checker judges every result word.
// ----------------------------------------------------------------------------
module deque_with_positional_insert_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import dq_pkg::*;

    localparam int CAPACITY = 16;
    localparam logic [2:0] OP_RESERVED_LO = 3'd6;
    localparam logic [2:0] OP_RESERVED_HI = 3'd7;

    logic clk = 1'b0;
    logic rst_n;

    int req_idle_pct;
    int rsp_idle_pct;
    int sent_words;

    int fail_count;
    int pending;
    int words_checked;
    int full_seen;
    int empty_seen;
    int nopos_seen;

    dq_req_if req_ch ();
    dq_rsp_if rsp_ch ();

    deque_with_positional_insert_top #(
        .CAPACITY(CAPACITY)
    ) dut (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (req_ch),
        .rsp  (rsp_ch)
    );

    deque_with_positional_insert_checker #(
        .CAPACITY(CAPACITY)
    ) checker_i (
        .clk          (clk),
        .rst_n        (rst_n),
        .req          (req_ch),
        .rsp          (rsp_ch),
        .fail_count   (fail_count),
        .pending      (pending),
        .words_checked(words_checked),
        .full_seen    (full_seen),
        .empty_seen   (empty_seen),
        .nopos_seen   (nopos_seen)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
        rsp_ch.ready <= ($urandom_range(99) >= rsp_idle_pct);

    function automatic logic [31:0] pick_value();
        if ($urandom_range(7) == 0)
        begin
            case ($urandom_range(3))
                0:       return 32'h7FFF_FFFF;
                1:       return 32'h8000_0000;
                2:       return 32'h0000_0000;
                default: return 32'hFFFF_FFFF;
            endcase
        end
        return $urandom();
    endfunction

    // Offers one request word and returns at the edge where it is taken.
    task automatic send_word(input logic [2:0] op, input logic [31:0] v,
                             input logic [7:0] pos);
        while ($urandom_range(99) < req_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid    <= 1'b1;
        req_ch.opcode   <= op;
        req_ch.value_in <= v;
        req_ch.position <= pos;
        do
            @(posedge clk);
        while (!req_ch.ready);
        if (op <= OP_READ_ALL)
            sent_words++;
    endtask

    task automatic wait_drained();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    // Fills from any state unless inserts hit it empty; then a full read-out.
    task automatic fill_burst();
        int roll;
        repeat (20)
        begin
            roll = $urandom_range(99);
            if (roll < 40)
                send_word(OP_PUSH_FRONT, pick_value(), 8'($urandom_range(255)));
            else if (roll < 80)
                send_word(OP_PUSH_REAR, pick_value(), 8'($urandom_range(255)));
            else
                send_word(OP_INSERT, pick_value(), 8'($urandom_range(1)));
        end
        send_word(OP_READ_ALL, pick_value(), 8'($urandom_range(255)));
    endtask

    task automatic drain_burst();
        repeat (18)
            send_word($urandom_range(1) ? OP_POP_FRONT : OP_POP_REAR, pick_value(),
                      8'($urandom_range(255)));
        send_word(OP_READ_ALL, pick_value(), 8'($urandom_range(255)));
    endtask

    task automatic run_random(input int target);
        int pick;
        int roll;
        while (sent_words < target)
        begin
            pick = $urandom_range(99);
            if (pick < 20)
                fill_burst();
            else if (pick < 35)
                drain_burst();
            else
            begin
                repeat (10)
                begin
                    roll = $urandom_range(99);
                    if (roll < 22)
                        send_word(OP_PUSH_FRONT, pick_value(), 8'($urandom_range(255)));
                    else if (roll < 44)
                        send_word(OP_PUSH_REAR, pick_value(), 8'($urandom_range(255)));
                    else if (roll < 58)
                        send_word(OP_POP_FRONT, pick_value(), 8'($urandom_range(255)));
                    else if (roll < 72)
                        send_word(OP_POP_REAR, pick_value(), 8'($urandom_range(255)));
                    else if (roll < 88)
                        send_word(OP_INSERT, pick_value(),
                                  8'(($urandom_range(7) == 0) ? $urandom_range(255)
                                                              : $urandom_range(18)));
                    else if (roll < 96)
                        send_word(OP_READ_ALL, pick_value(), 8'($urandom_range(255)));
                    else
                        send_word($urandom_range(1) ? OP_RESERVED_HI : OP_RESERVED_LO,
                                  pick_value(), 8'($urandom_range(255)));
                end
            end
        end
    endtask

    initial
    begin
        #3_200_000;
        $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        req_ch.valid    <= 1'b0;
        req_ch.opcode   <= OP_PUSH_FRONT;
        req_ch.value_in <= '0;
        req_ch.position <= '0;
        req_idle_pct = 26;
        rsp_idle_pct = 49;
        sent_words   = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty deque: pops, read-out and insert all refuse.
        send_word(OP_POP_FRONT, 32'h0, 8'd0);
        send_word(OP_POP_REAR, 32'h0, 8'd0);
        send_word(OP_READ_ALL, 32'h0, 8'd0);
        send_word(OP_INSERT, 32'h1111_1111, 8'd1);
        send_word(OP_PUSH_FRONT, 32'h7FFF_FFFF, 8'd0);
        send_word(OP_PUSH_REAR, 32'h8000_0000, 8'd255);
        send_word(OP_PUSH_FRONT, 32'h0000_0000, 8'd0);
        send_word(OP_PUSH_REAR, 32'hFFFF_FFFF, 8'd0);
        // Positions 0 and 1 both land at the front.
        send_word(OP_INSERT, 32'h1234_5678, 8'd0);
        send_word(OP_INSERT, 32'hA5A5_A5A5, 8'd1);
        send_word(OP_INSERT, 32'h5A5A_5A5A, 8'd6);
        send_word(OP_INSERT, 32'hDEAD_BEEF, 8'd8);
        send_word(OP_INSERT, 32'hDEAD_BEEF, 8'd255);
        send_word(OP_INSERT, 32'hC3C3_C3C3, 8'd3);
        send_word(OP_READ_ALL, 32'h0, 8'd0);
        send_word(OP_POP_FRONT, 32'h0, 8'd0);
        send_word(OP_POP_REAR, 32'h0, 8'd0);
        send_word(OP_RESERVED_LO, 32'hFFFF_FFFF, 8'd255);
        send_word(OP_RESERVED_HI, 32'h0, 8'd0);
        send_word(OP_READ_ALL, 32'h0, 8'd0);

        fill_burst();
        drain_burst();
        run_random(80);

        wait_drained();
        req_idle_pct = 49;
        rsp_idle_pct <= 26;
        run_random(145);

        wait_drained();
        req_idle_pct = 0;
        rsp_idle_pct <= 0;
        run_random(210);

        wait_drained();
        repeat (20) @(posedge clk);

        $display("Sent %0d request words under three idle mixes; %0d result words compared.",
                 sent_words, words_checked);
        $display("Refusals seen: %0d full, %0d empty, %0d bad position.",
                 full_seen, empty_seen, nopos_seen);
        if (fail_count == 0 && pending == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
